// ----- rtl/usan_pkg.sv -----
// Shared types and constants for the UTF-8 string sanitizer.
package usan_pkg;

   localparam logic [7:0] SubstByte  = 8'h5F;
   localparam logic [7:0] PrintLo    = 8'h20;
   localparam logic [7:0] PrintHi    = 8'h7E;
   localparam logic [7:0] Lead2Lo    = 8'hC2;
   localparam logic [7:0] Lead2Hi    = 8'hDF;
   localparam logic [7:0] Lead3Lo    = 8'hE0;
   localparam logic [7:0] Lead3Hi    = 8'hEF;
   localparam logic [7:0] Lead4Lo    = 8'hF0;
   localparam logic [7:0] Lead4Hi    = 8'hF4;
   localparam logic [7:0] TailLo     = 8'h80;
   localparam logic [7:0] TailHi     = 8'hBF;
   localparam logic [7:0] LeadE0     = 8'hE0;
   localparam logic [7:0] LeadE0Lo   = 8'hA0;
   localparam logic [7:0] LeadED     = 8'hED;
   localparam logic [7:0] LeadEDHi   = 8'h9F;
   localparam logic [7:0] LeadF0     = 8'hF0;
   localparam logic [7:0] LeadF0Lo   = 8'h90;
   localparam logic [7:0] LeadF4     = 8'hF4;
   localparam logic [7:0] LeadF4Hi   = 8'h8F;

   localparam int GroupSlots = 4;
   localparam int QDepth     = 2;
   localparam int QPtrW      = $clog2(QDepth);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_final;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_final;
   } rsp_item_type;

   // Bytes released by one input byte; last flag belongs to the final slot used
   typedef struct packed {
      logic [GroupSlots-1:0][7:0] bytes;
      logic [2:0]                 count;
      logic                       last;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ----- rtl/usan_front.sv -----
// Front end: classify each byte, track the pending sequence, build result groups.
module usan_front import usan_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         allow_multibyte,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   input  q_status_type q_status,
   output logic         push,
   output group_type    push_group
);

   logic [7:0] held_ff [0:2];
   logic [7:0] held_in [0:2];
   logic [1:0] held_count_ff, held_count_in;
   logic [2:0] seq_len_ff, seq_len_in;
   logic       accept;

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      if (b >= Lead2Lo && b <= Lead2Hi) len = 3'd2;
      else if (b >= Lead3Lo && b <= Lead3Hi) len = 3'd3;
      else if (b >= Lead4Lo && b <= Lead4Hi) len = 3'd4;
      return len;
   endfunction

   function automatic logic tail_ok(input logic [7:0] lead, input logic [1:0] pos,
                                    input logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = TailLo;
      hi = TailHi;
      if (pos == 2'd1) begin
         if (lead == LeadE0) lo = LeadE0Lo;
         else if (lead == LeadED) hi = LeadEDHi;
         else if (lead == LeadF0) lo = LeadF0Lo;
         else if (lead == LeadF4) hi = LeadF4Hi;
      end
      return (b >= lo) && (b <= hi);
   endfunction

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      logic       pending;
      logic       ok;
      logic [2:0] len;
      logic [2:0] prefix;
      logic [7:0] b;
      logic       fin;
      b   = in_item.data_byte;
      fin = in_item.is_final;
      pending = (held_count_ff != 2'd0);
      ok      = tail_ok(held_ff[0], held_count_ff, b);
      len     = allow_multibyte ? lead_length(b) : 3'd0;
      prefix  = 3'd0;

      held_in       = held_ff;
      held_count_in = held_count_ff;
      seq_len_in    = seq_len_ff;
      for (int k = 0; k < GroupSlots; k++) begin
         push_group.bytes[k] = SubstByte;
      end
      push_group.count = 3'd0;
      push_group.last  = fin;

      if (pending && ok) begin
         if (({1'b0, held_count_ff} + 3'd1) == seq_len_ff) begin
            // Sequence complete: release held bytes and this one
            for (int k = 0; k < 3; k++) begin
               if (k < int'(held_count_ff)) push_group.bytes[k] = held_ff[k];
            end
            push_group.bytes[held_count_ff] = b;
            push_group.count = {1'b0, held_count_ff} + 3'd1;
            held_count_in = 2'd0;
            seq_len_in    = 3'd0;
         end else if (!fin) begin
            // Extend the sequence
            held_in[held_count_ff] = b;
            held_count_in = held_count_ff + 2'd1;
         end else begin
            // String ends inside the sequence: replace everything
            push_group.count = {1'b0, held_count_ff} + 3'd1;
            held_count_in = 2'd0;
            seq_len_in    = 3'd0;
         end
      end else begin
         // No sequence pending, or it failed: replace any held bytes, then treat this byte as fresh
         if (pending) prefix = {1'b0, held_count_ff};
         held_count_in = 2'd0;
         seq_len_in    = 3'd0;
         if (b >= PrintLo && b <= PrintHi) begin
            push_group.bytes[prefix[1:0]] = b;
            push_group.count = prefix + 3'd1;
         end else if (len != 3'd0 && !fin) begin
            held_in[0]    = b;
            held_count_in = 2'd1;
            seq_len_in    = len;
            push_group.count = prefix;
            push_group.last  = 1'b0;
         end else begin
            push_group.count = prefix + 3'd1;
         end
      end
   end

   assign push = accept && (push_group.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         seq_len_ff    <= 3'd0;
      end else if (accept) begin
         held_count_ff <= held_count_in;
         seq_len_ff    <= seq_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_held_below_len: assert property (@(posedge clock) disable iff (reset)
      held_count_ff != 2'd0 |-> ({1'b0, held_count_ff} < seq_len_ff && seq_len_ff <= 3'd4))
      else $error("held count not below sequence length");

   a_idle_no_len: assert property (@(posedge clock) disable iff (reset)
      held_count_ff == 2'd0 |-> seq_len_ff == 3'd0)
      else $error("sequence length set with nothing held");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      accept && in_item.is_final |=> held_count_ff == 2'd0)
      else $error("bytes still held after end of string");
`endif

endmodule

// ----- rtl/usan_queue.sv -----
// Short group queue between the front end and the output serializer.
module usan_queue import usan_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  group_type    push_group,
   input  logic         pop,
   output group_type    head_group,
   output q_status_type q_status
);

   group_type          entry_ff [0:QDepth-1];
   logic [QPtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPtrW:0]     fill_ff, fill_in;

   assign q_status.full  = (fill_ff == (QPtrW+1)'(QDepth));
   assign q_status.empty = (fill_ff == '0);
   assign head_group     = entry_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) fill_in = fill_ff + 1'b1;
      else if (pop && !push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

// ----- rtl/usan_back.sv -----
// Back end: serialize each queued group into result bytes, one per cycle while the consumer is ready.
module usan_back import usan_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  group_type    head_group,
   input  q_status_type q_status,
   output logic         pop,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic [1:0] slot_ff, slot_in;
   logic       last_slot;

   assign last_slot = ({1'b0, slot_ff} == (head_group.count - 3'd1));
   assign out_valid = !q_status.empty;
   assign out_item.out_byte  = head_group.bytes[slot_ff];
   assign out_item.out_final = head_group.last && last_slot;
   assign pop = out_valid && out_ready && last_slot;

   always_comb begin
      slot_in = slot_ff;
      if (out_valid && out_ready) begin
         slot_in = last_slot ? 2'd0 : slot_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 2'd0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

// ----- rtl/utf8_string_sanitizer.sv -----
// Top level of the UTF-8 string sanitizer: front end, group queue, serializer.
// A byte that releases results is registered in the group queue before its first result appears.
// Throughput: one input byte per cycle while the queue is not full; output runs one result byte
//   per cycle while rsp_ready is high, and the two-group queue absorbs bursts.
// Reset: synchronous, active high; clears the held sequence, queue, and multibyte mode.
module utf8_string_sanitizer import usan_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,
   input  logic         csr_write_enable,
   input  logic         csr_write_data
);

   // Multibyte mode register; the user must write it only while the block is idle (not enforced here)
   logic         allow_multibyte_ff;

   // Group handoff between front end and serializer
   logic         push;
   logic         pop;
   group_type    push_group;
   group_type    head_group;
   q_status_type q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_multibyte_ff <= 1'b0;
      end else if (csr_write_enable) begin
         allow_multibyte_ff <= csr_write_data;
      end
   end

   // Classify bytes and hold candidate sequences; stall only when the queue is full
   usan_front u_front (
      .clock           (clock),
      .reset           (reset),
      .allow_multibyte (allow_multibyte_ff),
      .in_valid        (req_valid),
      .in_ready        (req_ready),
      .in_item         (req_data),
      .q_status        (q_status),
      .push            (push),
      .push_group      (push_group)
   );

   // Decouple the two sides so a stalled consumer does not block classification at once
   usan_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .head_group (head_group),
      .q_status   (q_status)
   );

   // Drain each group one byte per transaction; pop after its last byte
   usan_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_group (head_group),
      .q_status   (q_status),
      .pop        (pop),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_item   (rsp_data)
   );

endmodule
